// File: design/svm_pkg.sv
// ----------------------------------------------------------------------------
// svm_pkg
// Shared types, opcodes, register indexes and tables of the voice mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package svm_pkg;

  // Opcodes of an input item
  localparam logic [2:0] OP_SAMPLE_WR = 3'd0;
  localparam logic [2:0] OP_SEQ_WR    = 3'd1;
  localparam logic [2:0] OP_NOTE_ON   = 3'd2;
  localparam logic [2:0] OP_TICK      = 3'd3;
  localparam logic [2:0] OP_ALL_OFF   = 3'd4;
  localparam logic [2:0] OP_STOP      = 3'd5;

  // Configuration register indexes
  localparam logic REG_SEQ_COUNT  = 1'b0;
  localparam logic REG_STEP_SCALE = 1'b1;

  localparam logic [19:0] STEP_SCALE_RESET = 20'd8937;
  localparam logic [15:0] CLIP_THRESHOLD   = 16'd31130;
  localparam logic [17:0] CLIP_HOLD_START  = 18'd163840;
  // ceil(2^32 / 127): exact floor division for numerators below 2^25
  localparam logic [25:0] GAIN_RECIP       = 26'd33818641;

  // 2^(r/12) in Q1.16
  localparam logic [16:0] SEMI [12] = '{
    17'd65536, 17'd69433, 17'd73562, 17'd77936, 17'd82570, 17'd87480,
    17'd92682, 17'd98193, 17'd104032, 17'd110218, 17'd116772, 17'd123715
  };

  // tanh at steps of 0.25, Q1.15
  localparam logic [15:0] TANH [21] = '{
    16'd0, 16'd8026, 16'd15143, 16'd20813, 16'd24956, 16'd27797, 16'd29660,
    16'd30847, 16'd31589, 16'd32048, 16'd32329, 16'd32501, 16'd32606,
    16'd32670, 16'd32708, 16'd32732, 16'd32746, 16'd32755, 16'd32760,
    16'd32763, 16'd32765
  };

  typedef struct packed {
    logic [2:0]         opcode;
    logic [15:0]        address;
    logic signed [15:0] sample_value;
    logic [15:0]        clip_start;
    logic [16:0]        clip_length;
    logic [6:0]         note_pitch;
    logic [6:0]         velocity;
  } item_t;

  typedef struct packed {
    logic signed [15:0] audio_sample;
    logic [4:0]         active_voices;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic item_load;
    logic sample_wr;
    logic seq_wr;
    logic voices_off;
    logic seq_rewind;
    logic seq_rd;
    logic note_mul;
    logic note_wr;
    logic v_check;
    logic v_rd1;
    logic v_s1;
    logic v_mix;
    logic v_acc;
    logic v_next;
    logic div_load;
    logic div_step;
    logic clip_out;
  } svm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic note_ok;
    logic voice_live;
    logic last_voice;
  } svm_status_t;

  // Pitch ROM: right shift and semitone factor for a MIDI note
  function automatic logic [21:0] pitch_rom(input logic [6:0] pitch);
    logic [7:0]  e;
    logic [15:0] qm;
    logic [3:0]  q;
    logic [7:0]  r;
    logic [4:0]  sh;
    e  = 8'd129 - {1'b0, pitch};
    qm = (16'(e) * 16'd171) >> 11;
    q  = qm[3:0];
    r  = e - (8'(q) * 8'd12);
    sh = 5'd21 - {1'b0, q};
    return {sh, SEMI[r[3:0]]};
  endfunction

endpackage

`default_nettype wire

// File: design/svm_ram.sv
// ----------------------------------------------------------------------------
// svm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module svm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: design/svm_ctrl.sv
// ----------------------------------------------------------------------------
// svm_ctrl
// Controller: sequences note-on, per-voice mixing, division and soft clip.
// ----------------------------------------------------------------------------
`default_nettype none

module svm_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [2:0]           opcode,
  input  wire svm_pkg::svm_status_t status,
  output logic                      busy,
  output svm_pkg::svm_cmd_t         cmd
);
  import svm_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_NOTE_RD  = 12'b000000000010,
    S_NOTE_MUL = 12'b000000000100,
    S_NOTE_WR  = 12'b000000001000,
    S_V_CHECK  = 12'b000000010000,
    S_V_RD1    = 12'b000000100000,
    S_V_S1     = 12'b000001000000,
    S_V_MIX    = 12'b000010000000,
    S_V_ACC    = 12'b000100000000,
    S_DIV_LD   = 12'b001000000000,
    S_DIV      = 12'b010000000000,
    S_CLIP     = 12'b100000000000
  } state_t;

  state_t state, state_next;

  assign busy = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.item_load = 1'b1;
          case (opcode)
            OP_SAMPLE_WR: cmd.sample_wr = 1'b1;
            OP_SEQ_WR:    cmd.seq_wr = 1'b1;
            OP_NOTE_ON: begin
              if (status.note_ok) begin
                state_next = S_NOTE_RD;
              end
            end
            OP_TICK:      state_next = S_V_CHECK;
            OP_ALL_OFF:   cmd.voices_off = 1'b1;
            OP_STOP: begin
              cmd.voices_off = 1'b1;
              cmd.seq_rewind = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_NOTE_RD: begin
        cmd.seq_rd = 1'b1;
        state_next = S_NOTE_MUL;
      end
      S_NOTE_MUL: begin
        cmd.note_mul = 1'b1;
        state_next   = S_NOTE_WR;
      end
      S_NOTE_WR: begin
        cmd.note_wr = 1'b1;
        state_next  = S_IDLE;
      end
      S_V_CHECK: begin
        cmd.v_check = 1'b1;
        if (status.voice_live) begin
          state_next = S_V_RD1;
        end else begin
          cmd.v_next = 1'b1;
          if (status.last_voice) begin
            state_next = S_DIV_LD;
          end
        end
      end
      S_V_RD1: begin
        cmd.v_rd1  = 1'b1;
        state_next = S_V_S1;
      end
      S_V_S1: begin
        cmd.v_s1   = 1'b1;
        state_next = S_V_MIX;
      end
      S_V_MIX: begin
        cmd.v_mix  = 1'b1;
        state_next = S_V_ACC;
      end
      S_V_ACC: begin
        cmd.v_acc  = 1'b1;
        cmd.v_next = 1'b1;
        state_next = status.last_voice ? S_DIV_LD : S_V_CHECK;
      end
      S_DIV_LD: begin
        cmd.div_load = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        state_next   = S_CLIP;
      end
      S_CLIP: begin
        cmd.clip_out = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_tick_walks: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == OP_TICK) |=> state == S_V_CHECK)
    else $error("tick did not start the voice walk");

  a_note_seq: assert property (@(posedge clk) disable iff (rst)
    state == S_NOTE_RD |=> state == S_NOTE_MUL ##1 state == S_NOTE_WR)
    else $error("note-on sequence broken");

  a_div_to_clip: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |=> state == S_CLIP)
    else $error("divide did not lead to soft clip");

endmodule

`default_nettype wire

// File: design/svm_datapath.sv
// ----------------------------------------------------------------------------
// svm_datapath
// Datapath: memories, voice state, interpolation, mixing, divider, soft clip.
// ----------------------------------------------------------------------------
`default_nettype none

module svm_datapath #(
  parameter int VOICE_COUNT    = 16,
  parameter int SAMPLE_DEPTH   = 65536,
  parameter int SEQUENCE_DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire svm_pkg::item_t    item,
  input  wire svm_pkg::svm_cmd_t cmd,
  input  wire logic              cfg_valid,
  input  wire logic              cfg_index,
  input  wire logic [19:0]       cfg_data,
  output svm_pkg::svm_status_t   status,
  output logic                   result_valid,
  output svm_pkg::result_t       result
);
  import svm_pkg::*;

  localparam int SW     = $clog2(SAMPLE_DEPTH);
  localparam int QW     = (SEQUENCE_DEPTH > 1) ? $clog2(SEQUENCE_DEPTH) : 1;
  localparam int VW     = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int NW     = $clog2(VOICE_COUNT + 1);
  localparam int PROD_W = 42;
  localparam int ACC_W  = PROD_W + $clog2(VOICE_COUNT + 1);
  localparam int DIV_W  = ACC_W - 16;
  localparam int NUM_W  = 25;
  localparam int DP_W   = NUM_W + 26;
  localparam int QUOT_W = 19;

  // Configuration and sequence state
  logic [6:0]    seq_count;
  logic [19:0]   step_scale;
  logic [QW-1:0] seq_idx;
  logic [6:0]    seq_count_eff;

  // Latched item
  logic [6:0] pitch;
  logic [6:0] vel;

  // Voice state
  logic [VOICE_COUNT-1:0] voice_active;
  logic [32:0]            voice_pos   [VOICE_COUNT];
  logic [23:0]            voice_step  [VOICE_COUNT];
  logic [32:0]            voice_clip  [VOICE_COUNT];
  logic [6:0]             voice_gain  [VOICE_COUNT];
  logic [VW-1:0]          vidx;

  // Note-on pipeline
  logic [32:0] note_clip;
  logic [21:0] note_rom;
  logic [36:0] note_prod;
  logic [4:0]  note_shift;
  logic [36:0] note_shifted;
  logic [23:0] note_step;
  logic [VW-1:0] free_idx;
  logic          free_found;

  // Mixing
  logic [32:0]              cur_pos;
  logic [16:0]              cur_len;
  logic [15:0]              cur_start;
  logic [16:0]              cur_i;
  logic                     cur_end;
  logic [17:0]              base_addr;
  logic [17:0]              rd_addr_full;
  logic signed [15:0]       s0;
  logic signed [33:0]       fd;
  logic signed [PROD_W-1:0] prod;
  logic signed [33:0]       p_sum;
  logic signed [ACC_W-1:0]  acc;
  logic [NW-1:0]            n_cnt;

  // Divider and soft clip
  logic [ACC_W-1:0]  acc_mag;
  logic [DIV_W-1:0]  div_full;
  logic [NUM_W-1:0]  div_num;
  logic [DP_W-1:0]   div_prod;
  logic [QUOT_W-1:0] div_quot;
  logic              div_neg;
  logic [4:0]        t_idx;
  logic [15:0]       t_lo;
  logic [15:0]       t_diff;
  logic [25:0]       t_mul;
  logic [15:0]       clip_mag;

  // Memories
  logic [15:0] smp_rd_data;
  logic [32:0] seq_rd_data;
  logic        smp_we;
  logic        seq_we;

  assign seq_count_eff = (32'(seq_count) > SEQUENCE_DEPTH) ? 7'(SEQUENCE_DEPTH) : seq_count;

  assign smp_we = cmd.sample_wr && (32'(item.address) < SAMPLE_DEPTH);
  assign seq_we = cmd.seq_wr && (32'(item.address) < SEQUENCE_DEPTH);

  // Current voice fields
  assign cur_pos      = voice_pos[vidx];
  assign cur_len      = voice_clip[vidx][16:0];
  assign cur_start    = voice_clip[vidx][32:17];
  assign cur_i        = cur_pos[32:16];
  assign cur_end      = ({1'b0, cur_i} + 18'd1) >= {1'b0, cur_len};
  assign base_addr    = {2'b00, cur_start} + {1'b0, cur_i};
  assign rd_addr_full = cmd.v_rd1 ? (base_addr + 18'd1) : base_addr;

  assign status.note_ok    = (item.velocity != 7'd0) && (seq_count_eff != 7'd0);
  assign status.voice_live = voice_active[vidx] && !cur_end;
  assign status.last_voice = (vidx == VW'(VOICE_COUNT - 1));

  svm_ram #(.WIDTH(16), .DEPTH(SAMPLE_DEPTH)) u_sample_ram (
    .clk     (clk),
    .wr_en   (smp_we),
    .wr_addr (SW'(item.address)),
    .wr_data (item.sample_value),
    .rd_addr (SW'(rd_addr_full)),
    .rd_data (smp_rd_data)
  );

  svm_ram #(.WIDTH(33), .DEPTH(SEQUENCE_DEPTH)) u_seq_ram (
    .clk     (clk),
    .wr_en   (seq_we),
    .wr_addr (QW'(item.address)),
    .wr_data ({item.clip_start, item.clip_length}),
    .rd_addr (seq_idx),
    .rd_data (seq_rd_data)
  );

  // Configuration registers and sequence index
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_count  <= '0;
      step_scale <= STEP_SCALE_RESET;
      seq_idx    <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_SEQ_COUNT: begin
            seq_count <= cfg_data[6:0];
            seq_idx   <= '0;
          end
          REG_STEP_SCALE: step_scale <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.seq_rewind) begin
        seq_idx <= '0;
      end else if (cmd.seq_rd) begin
        seq_idx <= ((32'(seq_idx) + 32'd1) == 32'(seq_count_eff)) ? '0 : QW'(seq_idx + 1'b1);
      end
    end
  end

  // Find the first free voice slot
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int k = VOICE_COUNT - 1; k >= 0; k--) begin
      if (!voice_active[k]) begin
        free_idx   = VW'(k);
        free_found = 1'b1;
      end
    end
  end

  // Shift and saturate the step
  assign note_rom     = pitch_rom(pitch);
  assign note_shifted = note_prod >> note_shift;
  assign note_step    = (|note_shifted[36:24]) ? 24'hFFFFFF : note_shifted[23:0];

  // Voice activity
  always_ff @(posedge clk) begin
    if (rst) begin
      voice_active <= '0;
    end else if (cmd.voices_off) begin
      voice_active <= '0;
    end else if (cmd.note_wr && free_found && (note_clip[16:0] != 17'd0)) begin
      voice_active[free_idx] <= 1'b1;
    end else if (cmd.v_check && voice_active[vidx] && cur_end) begin
      voice_active[vidx] <= 1'b0;
    end
  end

  // Voice payload, note pipeline and per-voice arithmetic
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      pitch <= item.note_pitch;
      vel   <= item.velocity;
    end
    if (cmd.note_mul) begin
      note_clip <= seq_rd_data;
      note_prod <= 37'(step_scale) * 37'(note_rom[16:0]);
      note_shift <= note_rom[21:17];
    end
    if (cmd.note_wr && free_found && (note_clip[16:0] != 17'd0)) begin
      voice_pos[free_idx]  <= '0;
      voice_step[free_idx] <= note_step;
      voice_clip[free_idx] <= note_clip;
      voice_gain[free_idx] <= vel;
    end
    if (cmd.v_rd1) begin
      s0 <= smp_rd_data;
    end
    if (cmd.v_s1) begin
      fd <= $signed({1'b0, cur_pos[15:0]}) * ($signed({smp_rd_data[15], smp_rd_data})
            - $signed({s0[15], s0}));
    end
    if (cmd.v_mix) begin
      prod <= PROD_W'(p_sum) * PROD_W'($signed({1'b0, voice_gain[vidx]}));
    end
    if (cmd.v_acc) begin
      voice_pos[vidx] <= cur_pos + {9'd0, voice_step[vidx]};
    end
  end

  assign p_sum = $signed({{2{s0[15]}}, s0, 16'd0}) + fd;

  // Accumulator, voice counter and index
  always_ff @(posedge clk) begin
    if (rst) begin
      vidx <= '0;
    end else if (cmd.item_load) begin
      vidx <= '0;
    end else if (cmd.v_next) begin
      vidx <= VW'(vidx + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      acc   <= '0;
      n_cnt <= '0;
    end else if (cmd.v_acc) begin
      acc   <= acc + ACC_W'(prod);
      n_cnt <= NW'(n_cnt + 1'b1);
    end
  end

  // Divide the magnitude by 127 with a reciprocal multiply; clamp numerators
  // that already land past the tanh hold point
  assign acc_mag  = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign div_full = acc_mag[ACC_W-1:16];
  assign div_quot = div_prod[DP_W-1:32];

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      div_num <= (|div_full[DIV_W-1:NUM_W]) ? '1 : div_full[NUM_W-1:0];
      div_neg <= acc[ACC_W-1];
    end
    if (cmd.div_step) begin
      div_prod <= DP_W'(div_num) * DP_W'(GAIN_RECIP);
    end
  end

  // Soft clip through the tanh table
  assign t_idx  = div_quot[17:13];
  assign t_lo   = TANH[t_idx];
  assign t_diff = TANH[5'(t_idx + 5'd1)] - t_lo;
  assign t_mul  = 26'(t_diff[12:0]) * 26'(div_quot[12:0]);

  always_comb begin
    if (div_quot < QUOT_W'(CLIP_THRESHOLD)) begin
      clip_mag = div_quot[15:0];
    end else if (div_quot >= QUOT_W'(CLIP_HOLD_START)) begin
      clip_mag = TANH[20];
    end else begin
      clip_mag = t_lo + 16'(t_mul >> 13);
    end
  end

  // Result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.clip_out;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clip_out) begin
      result.audio_sample  <= div_neg ? -$signed(clip_mag) : $signed(clip_mag);
      result.active_voices <= 5'(n_cnt);
    end
  end

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe longer than one cycle");

endmodule

`default_nettype wire

// File: design/sample_playback_voice_mixer.sv
// ----------------------------------------------------------------------------
// sample_playback_voice_mixer
// Polyphonic sample-playback engine with linear interpolation and soft clip.
// ----------------------------------------------------------------------------
// Items are taken when start is high and busy is low. Sample writes, sequence
// writes, all-off and transport stop complete as they are taken; busy stays
// low. A note-on with nonzero velocity and a nonempty sequence steps through
// a sequence table read, a step multiply and a voice write. A tick walks the
// voice slots one at a time, checking each slot and reading, interpolating,
// mixing and accumulating each voice that plays, then loads the numerator,
// divides by 127 with one reciprocal multiply and soft clips. The result
// is shown for exactly one cycle on result_valid as busy falls; the receiver
// must take it then. SAMPLE_DEPTH must be a power of two. Configuration
// writes are always ready and are meant for idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

module sample_playback_voice_mixer #(
  parameter int VOICE_COUNT    = 16,
  parameter int SAMPLE_DEPTH   = 65536,
  parameter int SEQUENCE_DEPTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire svm_pkg::item_t   item,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_index,
  input  wire logic [19:0]      cfg_data,
  output logic                  result_valid,
  output svm_pkg::result_t      result
);
  import svm_pkg::*;

  svm_cmd_t    cmd;
  svm_status_t status;

  assign cfg_ready = 1'b1;

  svm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (item.opcode),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  svm_datapath #(
    .VOICE_COUNT    (VOICE_COUNT),
    .SAMPLE_DEPTH   (SAMPLE_DEPTH),
    .SEQUENCE_DEPTH (SEQUENCE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .status       (status),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire
